FILE: sv/pfi_pkg.sv
// Shared types and constants for the polyphase FIR interpolator.
// Used by the controller, the datapath, the top level and the port checker.
package pfi_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int COEF_W     = 18;
	localparam int PROD_W     = SAMPLE_W + COEF_W;
	localparam int ACC_W      = 48;
	localparam int RATIO_W    = 3;
	localparam int PLEN_W     = 7;
	localparam int PHASE_W    = 6;
	localparam int CIDX_W     = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam int SHIFT_W    = 5;

	// Q1.17 coefficient scale; the ratio shift is taken off this
	localparam int COEF_FRAC = 17;

	localparam logic [RATIO_W-1:0] RATIO_MIN = 3'd1;
	localparam logic [RATIO_W-1:0] RATIO_MAX = 3'd6;
	localparam logic [RATIO_W-1:0] RATIO_RST = 3'd1;
	localparam logic [PLEN_W-1:0]  PLEN_RST  = 7'd8;

	localparam logic signed [ACC_W-1:0]    SAT_HI = 48'sd8388607;
	localparam logic signed [ACC_W-1:0]    SAT_LO = -48'sd8388608;
	localparam logic signed [SAMPLE_W-1:0] OUT_HI = 24'h7F_FFFF;
	localparam logic signed [SAMPLE_W-1:0] OUT_LO = 24'h80_0000;

	typedef enum logic [0:0] {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RATIO = 1'b0,
		CFG_PLEN  = 1'b1
	} cfg_reg_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SETUP  = 6'b000010,
		ST_RUN    = 6'b000100,
		ST_DRAIN  = 6'b001000,
		ST_ROUND  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	typedef struct packed {
		logic               tap_wr;
		logic               push;
		logic               setup;
		logic               step;
		logic               round;
		logic               load;
		logic [PHASE_W-1:0] k;
		logic               last;
	} dp_cmd_t;

	typedef struct packed {
		logic [PHASE_W-1:0] l_m1;
		logic               last_step;
		logic               pipe_empty;
		logic               out_busy;
	} dp_sts_t;

	// clamp the ratio register into its meaningful range
	function automatic logic [RATIO_W-1:0] eff_ratio(input logic [RATIO_W-1:0] r);
		logic [RATIO_W-1:0] v;
		v = r;
		if (r < RATIO_MIN) v = RATIO_MIN;
		if (r > RATIO_MAX) v = RATIO_MAX;
		return v;
	endfunction

endpackage

FILE: sv/pfi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/pfi_ctrl.sv
// Sequencer for the interpolator: input handshake, phase and tap loop control.
// Depends on pfi_pkg; drives the datapath through dp_cmd_t, watches dp_sts_t.
module pfi_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             opcode,
	output logic             in_ready,
	input  pfi_pkg::dp_sts_t sts,
	output pfi_pkg::dp_cmd_t cmd
);
	import pfi_pkg::*;

	state_t             state_q, state_d;
	logic [PHASE_W-1:0] k_q, k_d;
	logic               accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d    = state_q;
		k_d        = k_q;
		cmd        = '0;
		cmd.k      = k_q;
		cmd.last   = (k_q == sts.l_m1);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (opcode == OP_SAMPLE) begin
						cmd.push = 1'b1;
						k_d      = '0;
						state_d  = ST_SETUP;
					end else begin
						cmd.tap_wr = 1'b1;
					end
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_RUN;
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				if (sts.last_step) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (sts.pipe_empty) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = ST_FINISH;
			end
			ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.load = 1'b1;
					if (k_q == sts.l_m1) begin
						state_d = ST_IDLE;
					end else begin
						k_d     = k_q + PHASE_W'(1);
						state_d = ST_SETUP;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

endmodule

FILE: sv/pfi_dp.sv
// Datapath: config registers, history and tap RAMs, address walk, MAC pipeline,
// rounding, saturation and the output register. Depends on pfi_pkg and pfi_ram.
module pfi_dp #(
	parameter int MAX_TAPS      = 512,
	parameter int MAX_PHASE_LEN = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  pfi_pkg::dp_cmd_t                      cmd,
	output pfi_pkg::dp_sts_t                      sts,
	input  logic                                  cfg_we,
	input  logic [pfi_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pfi_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic signed [pfi_pkg::SAMPLE_W-1:0]   sample_in,
	input  logic [pfi_pkg::CIDX_W-1:0]            coeff_index,
	input  logic signed [pfi_pkg::COEF_W-1:0]     coeff_value,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic signed [pfi_pkg::SAMPLE_W-1:0]   sample_out,
	output logic [pfi_pkg::PHASE_W-1:0]           phase_number,
	output logic                                  last
);
	import pfi_pkg::*;

	localparam int TAW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int HAW   = (MAX_PHASE_LEN > 1) ? $clog2(MAX_PHASE_LEN) : 1;
	localparam int PL_W  = $clog2(MAX_PHASE_LEN + 1);
	localparam int TP_W0 = $clog2(64 * (MAX_PHASE_LEN + 1));
	localparam int TP_W  = (TP_W0 > TAW + 1) ? TP_W0 : TAW + 1;
	localparam int HPW   = ((HAW > PL_W) ? HAW : PL_W) + 1;

	// configuration
	logic [RATIO_W-1:0] ratio_q;
	logic [PLEN_W-1:0]  plen_q;
	logic [RATIO_W-1:0] r_eff;
	logic [PHASE_W:0]   l_full;
	logic [PHASE_W-1:0] l_m1;
	logic [SHIFT_W-1:0] rshift;
	logic [PL_W-1:0]    p_eff, p_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RST;
			plen_q  <= PLEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RATIO: ratio_q <= cfg_data[RATIO_W-1:0];
				CFG_PLEN:  plen_q  <= cfg_data[PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign r_eff  = eff_ratio(ratio_q);
	assign l_full = (PHASE_W+1)'(1) << r_eff;
	assign l_m1   = PHASE_W'(l_full - (PHASE_W+1)'(1));
	assign rshift = SHIFT_W'(COEF_FRAC) - SHIFT_W'(r_eff);

	always_comb begin
		if (plen_q == '0) begin
			p_eff = PL_W'(1);
		end else if (int'(plen_q) > MAX_PHASE_LEN) begin
			p_eff = PL_W'(MAX_PHASE_LEN);
		end else begin
			p_eff = PL_W'(plen_q);
		end
	end
	assign p_m1 = p_eff - PL_W'(1);

	// history ring: head points at the newest sample, count saturates at depth
	logic [HAW-1:0]  head_q, head_nxt;
	logic [PL_W-1:0] count_q;

	assign head_nxt = (head_q == HAW'(MAX_PHASE_LEN - 1)) ? '0 : head_q + HAW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.push) begin
			head_q <= head_nxt;
			if (count_q != PL_W'(MAX_PHASE_LEN)) count_q <= count_q + PL_W'(1);
		end
	end

	// address walk: oldest used sample first, tap address steps by L
	logic [HAW-1:0]  hptr_q, hstart, hptr_inc;
	logic [TP_W-1:0] tptr_q;
	logic [PL_W-1:0] d_q;
	logic [HPW-1:0]  hdiff;
	logic            tap_oob, hist_void;

	assign hdiff    = HPW'(head_q) - HPW'(p_m1);
	assign hstart   = hdiff[HPW-1] ? HAW'(hdiff + HPW'(MAX_PHASE_LEN)) : HAW'(hdiff);
	assign hptr_inc = (hptr_q == HAW'(MAX_PHASE_LEN - 1)) ? '0 : hptr_q + HAW'(1);
	assign tap_oob  = (int'(tptr_q) >= MAX_TAPS);
	assign hist_void = (d_q >= count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hptr_q <= '0;
			tptr_q <= '0;
			d_q    <= '0;
		end else if (cmd.setup) begin
			hptr_q <= hstart;
			tptr_q <= TP_W'(l_m1 - cmd.k);
			d_q    <= p_m1;
		end else if (cmd.step) begin
			hptr_q <= hptr_inc;
			tptr_q <= tptr_q + TP_W'(l_full);
			d_q    <= d_q - PL_W'(1);
		end
	end

	// memories
	logic [SAMPLE_W-1:0]        hist_raw;
	logic [COEF_W-1:0]          tap_raw;
	logic signed [SAMPLE_W-1:0] hist_rd;
	logic signed [COEF_W-1:0]   tap_rd;
	logic                       tap_we;

	assign tap_we  = cmd.tap_wr && (int'(coeff_index) < MAX_TAPS);
	assign hist_rd = hist_raw;
	assign tap_rd  = tap_raw;

	pfi_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_PHASE_LEN)) u_hist_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (head_nxt),
		.wdata (sample_in),
		.raddr (hptr_q),
		.rdata (hist_raw)
	);

	pfi_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_tap_ram (
		.clk   (clk),
		.we    (tap_we),
		.waddr (TAW'(coeff_index)),
		.wdata (coeff_value),
		.raddr (tptr_q[TAW-1:0]),
		.rdata (tap_raw)
	);

	// MAC pipeline: s1 = RAM read, s2 = product, then accumulate
	logic                     valid_s1, zero_s1, valid_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q, bias, rnd_sum, rnd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.step;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= tap_oob || hist_void;
		if (zero_s1) begin
			prod_s2 <= '0;
		end else begin
			prod_s2 <= hist_rd * tap_rd;
		end
		if (cmd.setup) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// scale by L and drop to Q1.23 in one shift, round half up
	assign bias    = ACC_W'(1) << (rshift - SHIFT_W'(1));
	assign rnd_sum = acc_q + bias;

	always_ff @(posedge clk) begin
		if (cmd.round) rnd_q <= rnd_sum >>> rshift;
	end

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sat_val;

	always_comb begin
		priority if (rnd_q > SAT_HI) begin
			sat_val = OUT_HI;
		end else if (rnd_q < SAT_LO) begin
			sat_val = OUT_LO;
		end else begin
			sat_val = rnd_q[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_out   <= sat_val;
			phase_number <= cmd.k;
			last         <= cmd.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign sts.l_m1       = l_m1;
	assign sts.last_step  = (d_q == '0);
	assign sts.pipe_empty = !valid_s1 && !valid_s2;
	assign sts.out_busy   = out_valid_q && !out_ready;

endmodule

FILE: sv/polyphase_fir_interpolator.sv
// Polyphase FIR interpolator by L = 2^ratio_log2 (L = 2..64) with one shared
// 24x18 MAC. A coefficient beat (opcode 0) writes the tap RAM and gives no
// output. A sample beat (opcode 1) enters a history of phase_length samples
// and yields L output beats, phase_number 0..L-1, last on the final one.
// Each output walks its polyphase branch through the MAC one tap per cycle:
// P tap reads (P = phase_length), then pipeline drain, rounding and the
// output load, which waits for a ready consumer; input ready
// returns once the last output sits in the output register. The history and
// tap tables are single-port-read RAMs; the history reads zero for slots no
// sample has reached yet, tap addresses at or beyond MAX_TAPS read as zero,
// and taps never written are undefined. Results are rounded half up to Q1.23
// and saturated. Write ratio_log2 / phase_length only while the block is idle.
module polyphase_fir_interpolator #(
	parameter int MAX_TAPS      = 512,
	parameter int MAX_PHASE_LEN = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic signed [pfi_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [pfi_pkg::CIDX_W-1:0]          coeff_index,
	input  logic signed [pfi_pkg::COEF_W-1:0]   coeff_value,
	// output channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pfi_pkg::SAMPLE_W-1:0] sample_out,
	output logic [pfi_pkg::PHASE_W-1:0]         phase_number,
	output logic                                last,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [pfi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pfi_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import pfi_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// controller: takes the input beat, steps phases and taps
	pfi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: storage, MAC, rounding and the output beat register
	pfi_dp #(
		.MAX_TAPS      (MAX_TAPS),
		.MAX_PHASE_LEN (MAX_PHASE_LEN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_in    (sample_in),
		.coeff_index  (coeff_index),
		.coeff_value  (coeff_value),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.sample_out   (sample_out),
		.phase_number (phase_number),
		.last         (last)
	);

endmodule

FILE: sv/pfi_chk.sv
// Port-level checker for the interpolator, bound to the top level.
// Depends on pfi_pkg; tracks the ratio register and the phase sequence.
module pfi_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                opcode,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [pfi_pkg::SAMPLE_W-1:0] sample_out,
	input logic [pfi_pkg::PHASE_W-1:0]         phase_number,
	input logic                                last,
	input logic                                cfg_we,
	input logic [pfi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input logic [pfi_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import pfi_pkg::*;

	logic [RATIO_W-1:0] ratio_q;
	logic [PHASE_W-1:0] exp_q;
	logic [PHASE_W:0]   l_full;
	logic [PHASE_W-1:0] l_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RST;
			exp_q   <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_RATIO) ratio_q <= cfg_data[RATIO_W-1:0];
			if (out_valid && out_ready) begin
				exp_q <= last ? '0 : phase_number + PHASE_W'(1);
			end
		end
	end

	assign l_full = (PHASE_W+1)'(1) << eff_ratio(ratio_q);
	assign l_m1   = PHASE_W'(l_full - (PHASE_W+1)'(1));

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out)
			&& $stable(phase_number) && $stable(last))
		else $error("output beat changed while stalled");

	a_phase_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> phase_number == exp_q)
		else $error("phase_number out of sequence");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last == (phase_number == l_m1))
		else $error("last flag does not match interpolation factor");

	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == OP_SAMPLE |=> !in_ready)
		else $error("input taken while a sample run is in progress");

endmodule

bind polyphase_fir_interpolator pfi_chk u_pfi_chk (.*);
